@@ hdl/bdlp_pkg.sv @@
// Shared types and constants for the button debouncer with long-press detection.
// No dependencies; imported by bdlp_lane and button_debounce_long_press.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int unsigned BUTTONS_DEFAULT    = 4;
  localparam int unsigned TIME_WIDTH_DEFAULT = 64;

  localparam int unsigned LEVEL_WIDTH = 4;   // port width of the per-button masks
  localparam int unsigned IN_TIME_WIDTH = 64;
  localparam int unsigned CFG_WIDTH   = 32;
  localparam int unsigned FAULT_WIDTH = 32;
  localparam int unsigned CFG_IDX_WIDTH = 1;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 32'd20;
  localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 32'd1000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_LONG     = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_INIT   = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_e;

  // per-lane step control, all zero means hold
  typedef struct packed {
    logic init;
    logic fault;
    logic update;
  } lane_ctl_t;

endpackage

@@ hdl/button_debounce_long_press.sv @@
// Top level of the button debouncer with long-press detection.
// Depends on bdlp_pkg and bdlp_lane.
`timescale 1ns / 1ps

// Debounces up to four buttons from millisecond timestamps and reports
// press, release and long-press events. Every accepted word gives exactly one
// result word. An input register feeds per-button compare logic into an
// output register, so a word is taken every cycle while out_ready_i does not
// stall the output; the rate is set by the lane update, which makes two
// time subtract-and-compares per button. Timing registers written on
// the configuration port take effect at the next accepted initialize, and
// only if debounce_time is non-zero and long_press_time exceeds it; otherwise
// the initialize is answered with a reject status and changes nothing.
module button_debounce_long_press #(
  parameter int unsigned BUTTONS    = bdlp_pkg::BUTTONS_DEFAULT,
  parameter int unsigned TIME_WIDTH = bdlp_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [bdlp_pkg::CFG_WIDTH-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic [bdlp_pkg::LEVEL_WIDTH-1:0]     raw_levels_i,
  input  logic [bdlp_pkg::IN_TIME_WIDTH-1:0]   time_now_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 status_o,
  output logic [bdlp_pkg::LEVEL_WIDTH-1:0]     press_events_o,
  output logic [bdlp_pkg::LEVEL_WIDTH-1:0]     release_events_o,
  output logic [bdlp_pkg::LEVEL_WIDTH-1:0]     long_press_events_o,
  output logic [bdlp_pkg::LEVEL_WIDTH-1:0]     stable_levels_o,
  output logic                                 clock_fault_o,
  output logic [bdlp_pkg::FAULT_WIDTH-1:0]     fault_total_o
);
  import bdlp_pkg::*;

  // configuration and latched copies
  logic [CFG_WIDTH-1:0] deb_cfg_q, long_cfg_q;
  logic [CFG_WIDTH-1:0] deb_lat_q, long_lat_q;

  // input stage
  logic                  in_vld_q;
  logic                  cmd_q;
  logic [BUTTONS-1:0]    raw_q;
  logic [TIME_WIDTH-1:0] now_q;

  // shared state
  logic [TIME_WIDTH-1:0]  last_time_q;
  logic [FAULT_WIDTH-1:0] fault_cnt_q, fault_cnt_d;

  // output stage
  logic                   out_vld_q;
  logic                   status_q;
  logic [BUTTONS-1:0]     press_q, release_q, long_q, stable_q;
  logic                   fault_q;
  logic [FAULT_WIDTH-1:0] total_q;

  logic               advance;
  logic               is_init, init_ok, init_rej, time_back, do_fault, do_update;
  lane_ctl_t          lane_ctl;
  logic [BUTTONS-1:0] press_w, release_w, long_w, stable_w;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign is_init   = (cmd_q == CMD_INIT);
  assign init_ok   = is_init && (deb_cfg_q != '0) && (long_cfg_q > deb_cfg_q);
  assign init_rej  = is_init && !init_ok;
  assign time_back = (now_q < last_time_q);
  assign do_fault  = !is_init && time_back;
  assign do_update = !is_init && !time_back;

  assign lane_ctl.init   = advance && init_ok;
  assign lane_ctl.fault  = advance && do_fault;
  assign lane_ctl.update = advance && do_update;

  always_comb begin
    fault_cnt_d = fault_cnt_q;
    if (init_ok) begin
      fault_cnt_d = '0;
    end else if (do_fault) begin
      fault_cnt_d = fault_cnt_q + 1'b1;
    end
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    bdlp_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .raw_i     (raw_q[b]),
      .now_i     (now_q),
      .debounce_i(deb_lat_q),
      .long_i    (long_lat_q),
      .press_o   (press_w[b]),
      .release_o (release_w[b]),
      .long_o    (long_w[b]),
      .stable_o  (stable_w[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_cfg_q  <= DEBOUNCE_RESET;
      long_cfg_q <= LONG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE: deb_cfg_q  <= cfg_data_i;
        REG_LONG:     long_cfg_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_lat_q   <= DEBOUNCE_RESET;
      long_lat_q  <= LONG_RESET;
      last_time_q <= '0;
      fault_cnt_q <= '0;
    end else if (advance) begin
      if (init_ok) begin
        deb_lat_q  <= deb_cfg_q;
        long_lat_q <= long_cfg_q;
      end
      if (!init_rej) begin
        last_time_q <= now_q;
      end
      fault_cnt_q <= fault_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      raw_q <= raw_levels_i[BUTTONS-1:0];
      now_q <= time_now_i[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q  <= init_rej ? STATUS_REJECT : STATUS_OK;
      press_q   <= press_w;
      release_q <= release_w;
      long_q    <= long_w;
      stable_q  <= stable_w;
      fault_q   <= do_fault;
      total_q   <= fault_cnt_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign status_o            = status_q;
  assign press_events_o      = LEVEL_WIDTH'(press_q);
  assign release_events_o    = LEVEL_WIDTH'(release_q);
  assign long_press_events_o = LEVEL_WIDTH'(long_q);
  assign stable_levels_o     = LEVEL_WIDTH'(stable_q);
  assign clock_fault_o       = fault_q;
  assign fault_total_o       = total_q;

endmodule

@@ hdl/bdlp_lane.sv @@
// One button lane: candidate/stable levels, timestamps and event detection.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_lane #(
  parameter int unsigned TIME_WIDTH = bdlp_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bdlp_pkg::lane_ctl_t            ctl_i,
  input  logic                           raw_i,
  input  logic [TIME_WIDTH-1:0]          now_i,
  input  logic [bdlp_pkg::CFG_WIDTH-1:0] debounce_i,
  input  logic [bdlp_pkg::CFG_WIDTH-1:0] long_i,
  output logic                           press_o,
  output logic                           release_o,
  output logic                           long_o,
  output logic                           stable_o
);
  import bdlp_pkg::*;

  localparam int unsigned CmpWidth = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  logic                  cand_q, cand_d;
  logic                  stab_q, stab_d;
  logic                  lr_q, lr_d;
  logic [TIME_WIDTH-1:0] cand_start_q, cand_start_d;
  logic [TIME_WIDTH-1:0] press_start_q, press_start_d;

  logic [TIME_WIDTH-1:0] cand_elapsed;
  logic [TIME_WIDTH-1:0] press_elapsed;
  logic                  cand_held;
  logic                  press_held;
  logic                  long_zero;

  // elapsed times wrap modulo 2^TIME_WIDTH
  assign cand_elapsed  = now_i - cand_start_q;
  assign press_elapsed = now_i - press_start_q;
  assign cand_held  = CmpWidth'(cand_elapsed)  >= CmpWidth'(debounce_i);
  assign press_held = CmpWidth'(press_elapsed) >= CmpWidth'(long_i);
  assign long_zero  = (long_i == '0);

  always_comb begin
    cand_d        = cand_q;
    stab_d        = stab_q;
    lr_d          = lr_q;
    cand_start_d  = cand_start_q;
    press_start_d = press_start_q;
    press_o       = 1'b0;
    release_o     = 1'b0;
    long_o        = 1'b0;
    if (ctl_i.init) begin
      cand_d        = raw_i;
      stab_d        = raw_i;
      lr_d          = 1'b0;
      cand_start_d  = now_i;
      press_start_d = now_i;
    end else if (ctl_i.fault) begin
      cand_start_d = now_i;
    end else if (ctl_i.update) begin
      if (raw_i != cand_q) begin
        cand_d       = raw_i;
        cand_start_d = now_i;
      end else begin
        if ((cand_q != stab_q) && cand_held) begin
          stab_d = cand_q;
          lr_d   = 1'b0;
          if (cand_q) begin
            press_o       = 1'b1;
            press_start_d = now_i;
          end else begin
            release_o = 1'b1;
          end
        end
        // a press starting now has zero elapsed time
        if (stab_d && !lr_d && (press_o ? long_zero : press_held)) begin
          long_o = 1'b1;
          lr_d   = 1'b1;
        end
      end
    end
  end

  assign stable_o = stab_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q        <= 1'b0;
      stab_q        <= 1'b0;
      lr_q          <= 1'b0;
      cand_start_q  <= '0;
      press_start_q <= '0;
    end else begin
      cand_q        <= cand_d;
      stab_q        <= stab_d;
      lr_q          <= lr_d;
      cand_start_q  <= cand_start_d;
      press_start_q <= press_start_d;
    end
  end

endmodule
